[rtl/core/sliding_window_maximum_unit_assert.svh]
// Assertion macros for the sliding window maximum unit.
// Used by files in rtl/core; they expect clk and rst_n in scope.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding window maximum: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding window maximum: next-cycle check failed");

`endif

[rtl/core/swm_pkg.sv]
// Shared constants and types of the sliding window maximum unit.
// No dependencies; imported by swm_cell and the top level.
package swm_pkg;

  // parameter defaults
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // window size register
  localparam int            CFG_W     = 7;
  localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic accept;       // a sample request is taken this cycle
    logic restart;      // that sample clears the window first
    logic shift_front;  // oldest candidate expires on this accept
    logic shift_only;   // cleanup cycle: drop the oldest candidate
  } swm_ctrl_t;

endpackage

[rtl/core/swm_cell.sv]
// One candidate slot of the monotonic chain: value, age and valid flag.
// Depends on swm_pkg; besides the broadcast command and sample, talks only to its two neighbors.
module swm_cell
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int AGE_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swm_ctrl_t              ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  // older neighbor survives this sample
  input  logic                   left_keep,
  // newer neighbor, processed and current
  input  logic                   right_proc_valid,
  input  logic [SAMPLE_BITS-1:0] right_proc_value,
  input  logic [AGE_W-1:0]       right_proc_age,
  input  logic                   right_cur_valid,
  input  logic [SAMPLE_BITS-1:0] right_cur_value,
  input  logic [AGE_W-1:0]       right_cur_age,
  output logic                   keep,
  output logic                   proc_valid,
  output logic [SAMPLE_BITS-1:0] proc_value,
  output logic [AGE_W-1:0]       proc_age,
  output logic                   cur_valid,
  output logic [SAMPLE_BITS-1:0] cur_value,
  output logic [AGE_W-1:0]       cur_age
);

  logic                   valid_r, valid_nxt;
  logic [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic [AGE_W-1:0]       age_r, age_nxt;
  logic [AGE_W-1:0]       age_inc;
  logic                   append;

  // aging, saturating at the window limit
  assign age_inc = (age_r == AGE_W'(WINDOW_MAX)) ? age_r : age_r + AGE_W'(1);

  // survive unless restarted or not greater than the new sample
  assign keep   = valid_r && !ctrl.restart && ($signed(value_r) > $signed(sample));
  // the sample lands just past the last survivor
  assign append = !keep && left_keep;

  assign proc_valid = keep || append;
  assign proc_value = keep ? value_r : sample;
  assign proc_age   = keep ? age_inc : '0;

  assign cur_valid = valid_r;
  assign cur_value = value_r;
  assign cur_age   = age_r;

  // next slot contents
  always_comb begin
    priority if (ctrl.accept) begin
      if (ctrl.shift_front) begin
        valid_nxt = right_proc_valid;
        value_nxt = right_proc_value;
        age_nxt   = right_proc_age;
      end else begin
        valid_nxt = proc_valid;
        value_nxt = proc_value;
        age_nxt   = proc_age;
      end
    end else if (ctrl.shift_only) begin
      valid_nxt = right_cur_valid;
      value_nxt = right_cur_value;
      age_nxt   = right_cur_age;
    end else begin
      valid_nxt = valid_r;
      value_nxt = value_r;
      age_nxt   = age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

endmodule

[rtl/core/sliding_window_maximum_unit.sv]
// Top level of the sliding window maximum unit: cell chain, control, output register.
// Depends on swm_pkg, swm_cell and sliding_window_maximum_unit_assert.svh.
//
// Usage:
//  - in_*: one signed sample per request in in_tdata; in_tuser[0] = restart,
//    which empties the window before that sample is taken in.
//  - out_*: one result per sample once window_size samples have arrived since
//    the last restart; out_tdata holds the largest of the last window_size.
//  - cfg_*: writes window_size (7 bits, 0 acts as 1, above WINDOW_MAX acts as
//    WINDOW_MAX); cfg_ready is always high. Write only while the unit is idle.
// Timing:
//  - A taken sample is held pending first; its result is then written into the output register.
//  - One sample per cycle in steady state. The oldest candidate that leaves
//    the window is dropped in the accept cycle itself; each further candidate
//    that expires (after window_size shrinks) is dropped by a cleanup step of
//    the front-shift loop, during which in_tready is low.
//  - If the receiver stalls, one result waits in the output register while the
//    next sample is still taken; the one after that waits for out_tready.
// Reset: window_size returns to 3, the chain and the fill count are cleared.
module sliding_window_maximum_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // sample requests
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [0:0]         in_tuser,   // [0] restart
  // results
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [SAMPLE_BITS-1:0] window_max, rest zero
  // window_size writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data
);

  `include "sliding_window_maximum_unit_assert.svh"

  localparam int AGE_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (AGE_W > CFG_W) ? AGE_W : CFG_W;
  localparam int N     = WINDOW_MAX;

  logic [CFG_W-1:0]       win_r, win_nxt;
  logic [CMP_W-1:0]       win_ext;
  logic [AGE_W-1:0]       w_eff;
  logic [AGE_W-1:0]       fill_r, fill_nxt;
  logic                   pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r, out_data_nxt;

  logic                   in_accept;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   front_exp;
  logic                   need_emit;
  logic                   out_free;
  logic                   resolve;
  logic                   emit;
  swm_ctrl_t              ctrl;

  // chain wiring
  logic [N-1:0]           keep;
  logic [N-1:0]           left_keep;
  logic [N-1:0]           proc_valid;
  logic [SAMPLE_BITS-1:0] proc_value [N];
  logic [AGE_W-1:0]       proc_age   [N];
  logic [N-1:0]           cur_valid;
  logic [SAMPLE_BITS-1:0] cur_value  [N];
  logic [AGE_W-1:0]       cur_age    [N];
  logic [N-1:0]           r_proc_valid;
  logic [SAMPLE_BITS-1:0] r_proc_value [N];
  logic [AGE_W-1:0]       r_proc_age   [N];
  logic [N-1:0]           r_cur_valid;
  logic [SAMPLE_BITS-1:0] r_cur_value  [N];
  logic [AGE_W-1:0]       r_cur_age    [N];
  logic [N-2:0]           order_ok;

  assign sample    = in_tdata[SAMPLE_BITS-1:0];
  assign cfg_ready = 1'b1;

  // effective window size, clamped to 1..WINDOW_MAX
  assign win_ext = CMP_W'(win_r);
  always_comb begin
    priority if (win_ext == '0) begin
      w_eff = AGE_W'(1);
    end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
      w_eff = AGE_W'(WINDOW_MAX);
    end else begin
      w_eff = AGE_W'(win_ext);
    end
  end

  // front candidate already out of the window: needs a cleanup shift
  assign front_exp = cur_valid[0] && (cur_age[0] >= w_eff);
  assign need_emit = fill_r >= w_eff;
  assign out_free  = !out_valid_r || out_tready;
  assign resolve   = pend_r && !front_exp && (!need_emit || out_free);
  assign emit      = resolve && need_emit;

  assign in_tready = !pend_r || resolve;
  assign in_accept = in_tvalid && in_tready;

  // cell command
  always_comb begin
    ctrl.accept      = in_accept;
    ctrl.restart     = in_tuser[0];
    ctrl.shift_front = keep[0] && (proc_age[0] >= w_eff);
    ctrl.shift_only  = pend_r && front_exp;
  end

  // control next state
  always_comb begin
    win_nxt = cfg_valid ? cfg_data : win_r;

    fill_nxt = fill_r;
    if (in_accept) begin
      if (in_tuser[0]) begin
        fill_nxt = AGE_W'(1);
      end else if (fill_r != AGE_W'(WINDOW_MAX)) begin
        fill_nxt = fill_r + AGE_W'(1);
      end
    end

    pend_nxt = in_accept ? 1'b1 : (resolve ? 1'b0 : pend_r);

    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt  = emit ? cur_value[0] : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RESET;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);

  // row of cells, oldest candidate at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_keep[i] = 1'b1;
    end else begin : g_mid
      assign left_keep[i] = keep[i-1];
    end

    if (i == N - 1) begin : g_last
      // a sample appended past the last slot moves in on the front shift
      assign r_proc_valid[i] = keep[i];
      assign r_proc_value[i] = sample;
      assign r_proc_age[i]   = '0;
      assign r_cur_valid[i]  = 1'b0;
      assign r_cur_value[i]  = '0;
      assign r_cur_age[i]    = '0;
    end else begin : g_link
      assign r_proc_valid[i] = proc_valid[i+1];
      assign r_proc_value[i] = proc_value[i+1];
      assign r_proc_age[i]   = proc_age[i+1];
      assign r_cur_valid[i]  = cur_valid[i+1];
      assign r_cur_value[i]  = cur_value[i+1];
      assign r_cur_age[i]    = cur_age[i+1];
      assign order_ok[i]     = !cur_valid[i+1] ||
                               ($signed(cur_value[i]) > $signed(cur_value[i+1]));
    end

    swm_cell #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk              (clk),
      .rst_n            (rst_n),
      .ctrl             (ctrl),
      .sample           (sample),
      .left_keep        (left_keep[i]),
      .right_proc_valid (r_proc_valid[i]),
      .right_proc_value (r_proc_value[i]),
      .right_proc_age   (r_proc_age[i]),
      .right_cur_valid  (r_cur_valid[i]),
      .right_cur_value  (r_cur_value[i]),
      .right_cur_age    (r_cur_age[i]),
      .keep             (keep[i]),
      .proc_valid       (proc_valid[i]),
      .proc_value       (proc_value[i]),
      .proc_age         (proc_age[i]),
      .cur_valid        (cur_valid[i]),
      .cur_value        (cur_value[i]),
      .cur_age          (cur_age[i])
    );
  end

  // a new sample is never taken over a stale front candidate
  `SWM_ASSERT_NOW(a_clean_front_on_accept, in_accept && pend_r, !front_exp)
  // results only once the window has filled
  `SWM_ASSERT_NOW(a_emit_filled, emit, fill_r >= w_eff)
  // live candidates stay packed at the oldest end
  `SWM_ASSERT_NOW(a_valid_prefix, 1'b1, (cur_valid & (cur_valid + 1'b1)) == '0)
  // candidate values fall strictly from oldest to newest
  `SWM_ASSERT_NOW(a_decreasing, 1'b1, &order_ok)
  // every taken sample leaves a decision pending
  `SWM_ASSERT_NEXT(a_accept_pends, in_accept, pend_r)

endmodule
